// File: hw/rtl/josp_pkg.sv
`default_nettype none

package josp_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int COUNT_W   = 16;
	localparam int PERSON_W  = 7;
	localparam logic [COUNT_W-1:0] START_COUNT_RST = COUNT_W'(1);

	typedef struct packed {
		logic [COUNT_W-1:0] password;
		logic               last_person;
	} in_item_t;

	typedef struct packed {
		logic [PERSON_W-1:0] person_number;
		logic                last_out;
	} out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/josp_ram.sv
`default_nettype none

module josp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/josp_mod.sv
`default_nettype none

module josp_mod #(
	parameter int DW = 16,
	parameter int CW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [CW-1:0] divisor,
	output logic               done,
	output logic      [CW-1:0] remainder
);

	localparam int NW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [CW-1:0] dsr_q;
	logic [CW-1:0] rem_q;
	logic [CW:0]   shifted;
	logic [CW:0]   diff;

	assign shifted = {rem_q, dvd_q[DW-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			if (shifted >= {1'b0, dsr_q}) begin
				rem_q <= diff[CW-1:0];
			end else begin
				rem_q <= shifted[CW-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/josephus_password_elimination.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid/cfg_ready    cfg_data: start_count
// in        in         in_valid/in_ready      in_data: password, last_person
// out       out        out_valid/out_ready    out_data: person_number, last_out
//
// Loading accepts one item per cycle; in_ready is low from the last item until the
// survivor has been registered for output.
// Each removal runs the shift-subtract remainder unit (start, one step per count
// bit, done), then one set-up read, then the walk through the link memory, whose
// registered read gives the next address, at one ring step per cycle, and then emits
// the item; the survivor is emitted last, from S_FINAL.
// Reset clears control state only; both memories hold stale data until written.
// A stalled out channel holds the walk on the chosen person until the slot frees.
`default_nettype none

module josephus_password_elimination #(
	parameter int DEPTH = josp_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [josp_pkg::COUNT_W-1:0] cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire josp_pkg::in_item_t           in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output josp_pkg::out_item_t               out_data
);

	import josp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int NW = (AW + 1 > PERSON_W) ? AW + 1 : PERSON_W;

	typedef enum logic [4:0] {
		S_LOAD  = 5'b00001,
		S_DIV   = 5'b00010,
		S_RD    = 5'b00100,
		S_WALK  = 5'b01000,
		S_FINAL = 5'b10000
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] start_q;
	logic [COUNT_W-1:0] count_q;
	logic [CW-1:0]      loaded_q;
	logic [CW-1:0]      rem_q;
	logic [CW-1:0]      steps_q;
	logic [AW-1:0]      cur_q;
	logic [AW-1:0]      prev_q;
	logic               div_run_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic               in_acc;
	logic               is_full;
	logic [CW-1:0]      n_next;
	logic [CW-1:0]      rem_dec;
	logic               out_free;
	logic               emit;
	out_item_t          emit_item;
	logic [NW-1:0]      num;
	logic               div_start;
	logic               div_done;
	logic [CW-1:0]      div_rem;
	logic               pw_we;
	logic               link_we;
	logic [AW-1:0]      link_waddr;
	logic [AW-1:0]      link_wdata;
	logic [AW-1:0]      rd_addr;
	logic [COUNT_W-1:0] pw_rd;
	logic [AW-1:0]      link_rd;
	logic               take;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign is_full   = (loaded_q == CW'(DEPTH));
	assign n_next    = is_full ? loaded_q : loaded_q + CW'(1);
	assign rem_dec   = rem_q - CW'(1);
	assign out_free  = !out_valid_q || out_ready;
	assign num       = NW'(cur_q) + NW'(1);
	assign div_start = (state_q == S_DIV) && !div_run_q;
	assign take      = (state_q == S_WALK) && (steps_q == '0) && out_free;

	always_comb begin
		emit                    = 1'b0;
		emit_item.person_number = num[PERSON_W-1:0];
		emit_item.last_out      = 1'b0;
		if (take) begin
			emit = 1'b1;
		end else if ((state_q == S_FINAL) && out_free) begin
			emit               = 1'b1;
			emit_item.last_out = 1'b1;
		end
	end

	always_comb begin
		pw_we      = in_acc && !is_full;
		link_we    = pw_we || take;
		link_waddr = loaded_q[AW-1:0];
		link_wdata = (in_data.last_person || loaded_q == CW'(DEPTH - 1)) ?
			'0 : AW'(loaded_q + CW'(1));
		if (take) begin
			link_waddr = prev_q;
			link_wdata = link_rd;
		end
		rd_addr = cur_q;
		if ((state_q == S_WALK) && (steps_q != '0)) begin
			rd_addr = link_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			count_q   <= '0;
			loaded_q  <= '0;
			rem_q     <= '0;
			steps_q   <= '0;
			cur_q     <= '0;
			prev_q    <= '0;
			div_run_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						loaded_q <= n_next;
						if (in_data.last_person) begin
							rem_q   <= n_next;
							cur_q   <= '0;
							prev_q  <= AW'(n_next - CW'(1));
							count_q <= (start_q == '0) ? COUNT_W'(1) : start_q;
							state_q <= (n_next == CW'(1)) ? S_FINAL : S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_start) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						steps_q   <= div_rem;
						state_q   <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (steps_q != '0) begin
						prev_q  <= cur_q;
						cur_q   <= link_rd;
						steps_q <= steps_q - CW'(1);
					end else if (take) begin
						count_q <= (pw_rd == '0) ? COUNT_W'(1) : pw_rd;
						cur_q   <= link_rd;
						rem_q   <= rem_dec;
						state_q <= (rem_dec == CW'(1)) ? S_FINAL : S_DIV;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						loaded_q <= '0;
						rem_q    <= '0;
						state_q  <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_item_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

	josp_mod #(
		.DW(COUNT_W),
		.CW(CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (count_q - COUNT_W'(1)),
		.divisor  (rem_q),
		.done     (div_done),
		.remainder(div_rem)
	);

	josp_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_pw_ram (
		.clk  (clk),
		.we   (pw_we),
		.waddr(loaded_q[AW-1:0]),
		.wdata(in_data.password),
		.raddr(rd_addr),
		.rdata(pw_rd)
	);

	josp_ram #(
		.WIDTH(AW),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(rd_addr),
		.rdata(link_rd)
	);

endmodule

`default_nettype wire

// File: hw/rtl/josp_check.sv
`default_nettype none

module josp_check (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cfg_valid,
	input wire logic                         cfg_ready,
	input wire logic [josp_pkg::COUNT_W-1:0] cfg_data,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire josp_pkg::in_item_t           in_data,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire josp_pkg::out_item_t          out_data
);

	import josp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("out item changed while stalled");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg channel not ready");

	a_load_on: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.last_person |=> in_ready)
		else $error("loading stopped before last item");

	a_run_off: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_person |=> !in_ready)
		else $error("item taken during elimination");

endmodule

bind josephus_password_elimination josp_check u_check (.*);

`default_nettype wire
